// ----- src/assert_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside of reset only.
`define RARA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check on every edge, reset included.
`define RARA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ----- src/rara_pkg.sv -----
package rara_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_BITS   = 16;
  localparam int NODE_COUNT   = 4 * MAX_ELEMENTS;
  localparam int NODE_BITS    = $clog2(NODE_COUNT);
  localparam int IDX_BITS     = 10;
  localparam int SIZE_BITS    = 11;
  localparam int SUM_BITS     = 26;
  localparam int VAL_BITS     = 16;
  localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS) + 2;
  localparam int SP_BITS      = $clog2(STACK_DEPTH);
  localparam int SH_BITS      = $clog2(SIZE_BITS);
  localparam int CNT_BITS     = $clog2(SUM_BITS);

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);
  localparam logic [SIZE_BITS-1:0] MAX_N      = SIZE_BITS'(MAX_ELEMENTS);
  localparam logic [VAL_BITS-1:0]  VAL_MASK   = VAL_BITS'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ASSIGN = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [VAL_BITS-1:0] pval;
    logic                pflag;
  } node_t;

  typedef struct packed {
    logic                start;
    logic                clear;
    logic                assign_op;
    logic [IDX_BITS-1:0] x;
    logic [IDX_BITS-1:0] y;
    logic [IDX_BITS-1:0] hi;
    logic [VAL_BITS-1:0] value;
  } walk_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SUM_BITS-1:0] sum;
  } walk_rsp_t;

endpackage

// ----- src/range_assign_range_average.sv -----
// Each tree node visited takes a registered read and an evaluate step; a node with a pending
// value first pushes it to the left child, then to the right child, then clears it in the node;
// each child return takes a return step, and on assign each fully covered node is written.
// A query adds a binary gcd and a bit-serial division of sum and length by it on the
// shared subtractor; a zero sum skips both. Only one item is in work at a time.
// Reset: a clearing pass over all node entries, in_stall high; clear does same.
module range_assign_range_average (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [rara_pkg::IDX_BITS-1:0]  in_first_index,
  input  logic [rara_pkg::IDX_BITS-1:0]  in_second_index,
  input  logic [rara_pkg::VAL_BITS-1:0]  in_assign_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rara_pkg::SUM_BITS-1:0]  out_numerator,
  output logic [rara_pkg::SIZE_BITS-1:0] out_denominator,
  input  logic                           cfg_wr_en,
  input  logic [rara_pkg::SIZE_BITS-1:0] cfg_wr_data
);
  import rara_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_WALK, T_FRAC} top_state_t;

  top_state_t           st_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 start_r, frac_start_r, query_r;
  walk_req_t            req_r;
  logic                 out_valid_r;
  logic [SUM_BITS-1:0]  num_r;
  logic [SIZE_BITS-1:0] den_r;

  walk_req_t            req;
  walk_rsp_t            rsp;
  logic                 accept, slot_free, frac_valid, frac_ack;
  logic [SIZE_BITS-1:0] n, len;
  logic [IDX_BITS-1:0]  xa, ya, lo_i, hi_i;
  logic [SUM_BITS-1:0]  frac_num;
  logic [SIZE_BITS-1:0] frac_den;

  assign in_stall  = (st_r != T_IDLE) || rsp.busy;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign frac_ack  = (st_r == T_FRAC) && frac_valid && slot_free;

  // clamp size and indices, order the range
  always_comb begin
    n = size_r;
    if (size_r == '0) begin
      n = SIZE_BITS'(1);
    end else if (size_r > MAX_N) begin
      n = MAX_N;
    end
    xa   = ({1'b0, in_first_index} >= n) ? IDX_BITS'(n - 1'b1) : in_first_index;
    ya   = ({1'b0, in_second_index} >= n) ? IDX_BITS'(n - 1'b1) : in_second_index;
    lo_i = (xa > ya) ? ya : xa;
    hi_i = (xa > ya) ? xa : ya;
  end

  always_comb begin
    req       = req_r;
    req.start = start_r;
    len       = SIZE_BITS'({1'b0, req_r.y} - {1'b0, req_r.x} + 1'b1);
  end

  rara_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  rara_frac u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (frac_start_r),
    .sum       (rsp.sum),
    .len       (len),
    .ack       (frac_ack),
    .res_valid (frac_valid),
    .num       (frac_num),
    .den       (frac_den)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= T_IDLE;
      size_r       <= SIZE_RESET;
      start_r      <= 1'b0;
      frac_start_r <= 1'b0;
      query_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      start_r      <= accept && (in_command inside {CMD_CLEAR, CMD_ASSIGN, CMD_QUERY});
      frac_start_r <= (st_r == T_WALK) && rsp.done && query_r;
      // hold a stalled result beat, load a new one when the slot frees
      out_valid_r  <= frac_ack || (out_valid_r && out_stall);
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      unique case (st_r)
        T_IDLE: begin
          if (accept) begin
            req_r.start     <= 1'b0;
            req_r.clear     <= (in_command == CMD_CLEAR);
            req_r.assign_op <= (in_command == CMD_ASSIGN);
            req_r.x         <= lo_i;
            req_r.y         <= hi_i;
            req_r.hi        <= IDX_BITS'(n - 1'b1);
            req_r.value     <= in_assign_value & VAL_MASK;
            query_r         <= (in_command == CMD_QUERY);
            if (in_command inside {CMD_CLEAR, CMD_ASSIGN, CMD_QUERY}) begin
              st_r <= T_WALK;
            end
          end
        end
        T_WALK: begin
          if (rsp.done) begin
            st_r <= query_r ? T_FRAC : T_IDLE;
          end
        end
        T_FRAC: begin
          if (frac_ack) begin
            num_r <= frac_num;
            den_r <= frac_den;
            st_r  <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = num_r;
  assign out_denominator = den_r;

endmodule

// ----- src/rara_mem.sv -----
module rara_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [rara_pkg::NODE_BITS-1:0] wr_addr,
  input  rara_pkg::node_t               wr_data,
  input  logic [rara_pkg::NODE_BITS-1:0] rd_addr,
  output rara_pkg::node_t               rd_data_r
);
  import rara_pkg::*;

  node_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- src/rara_walk.sv -----
module rara_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  rara_pkg::walk_req_t req,
  output rara_pkg::walk_rsp_t rsp
);
  import rara_pkg::*;

  typedef enum logic [3:0] {
    W_CLEAR, W_IDLE, W_READ, W_EVAL, W_FULL, W_PUSH_A, W_PUSH_B, W_PUSH_K, W_RET
  } walk_state_t;

  walk_state_t          state_r;
  logic [NODE_BITS-1:0] clr_addr_r;
  logic                 clr_cmd_r;
  logic                 done_r;
  logic [SP_BITS-1:0]   sp_r;
  logic [SUM_BITS-1:0]  ret_r;
  logic [SUM_BITS-1:0]  prod_r;
  logic [VAL_BITS-1:0]  pval_r;
  logic [SUM_BITS-1:0]  nsum_r;

  logic [NODE_BITS-1:0] fk   [STACK_DEPTH];
  logic [IDX_BITS-1:0]  flo  [STACK_DEPTH];
  logic [IDX_BITS-1:0]  fhi  [STACK_DEPTH];
  logic                 fph  [STACK_DEPTH];
  logic [SUM_BITS-1:0]  facc [STACK_DEPTH];

  logic [NODE_BITS-1:0] tk, kl, kr;
  logic [IDX_BITS-1:0]  tlo, thi, mid;
  logic                 tph;
  logic [SUM_BITS-1:0]  tacc;
  logic [SP_BITS-1:0]   sp_up;
  logic                 outside, covers;
  node_t                nd;
  logic                 mem_we;
  logic [NODE_BITS-1:0] mem_waddr, mem_raddr;
  node_t                mem_wdata;
  logic [SIZE_BITS-1:0] mul_len;
  logic [VAL_BITS-1:0]  mul_val;
  logic                 done_nxt;

  rara_mem u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr   (mem_raddr),
    .rd_data_r (nd)
  );

  always_comb begin
    tk      = fk[sp_r];
    tlo     = flo[sp_r];
    thi     = fhi[sp_r];
    tph     = fph[sp_r];
    tacc    = facc[sp_r];
    kl      = {tk[NODE_BITS-2:0], 1'b0};
    kr      = {tk[NODE_BITS-2:0], 1'b1};
    mid     = IDX_BITS'(({1'b0, tlo} + {1'b0, thi}) >> 1);
    sp_up   = SP_BITS'(sp_r + 1'b1);
    outside = (tlo > req.y) || (thi < req.x);
    covers  = (tlo >= req.x) && (thi <= req.y);
  end

  always_comb begin
    mem_raddr = tk;
    mem_we    = 1'b0;
    mem_waddr = tk;
    mem_wdata = '0;
    case (state_r)
      W_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      W_FULL: begin
        mem_we    = 1'b1;
        mem_wdata = '{sum: prod_r, pval: req.value, pflag: 1'b1};
      end
      W_PUSH_A: begin
        mem_we    = 1'b1;
        mem_waddr = kl;
        mem_wdata = '{sum: prod_r, pval: pval_r, pflag: 1'b1};
      end
      W_PUSH_B: begin
        mem_we    = 1'b1;
        mem_waddr = kr;
        mem_wdata = '{sum: prod_r, pval: pval_r, pflag: 1'b1};
      end
      W_PUSH_K: begin
        mem_we    = 1'b1;
        mem_wdata = '{sum: nsum_r, pval: '0, pflag: 1'b0};
      end
      W_RET: begin
        mem_we    = tph && req.assign_op;
        mem_wdata = '{sum: tacc + ret_r, pval: '0, pflag: 1'b0};
      end
      default: ;
    endcase
  end

  // shared multiplier operands: element count times value
  always_comb begin
    mul_len = SIZE_BITS'({1'b0, thi} - {1'b0, tlo} + 1'b1);
    mul_val = req.value;
    case (state_r)
      W_EVAL: begin
        if (!covers) begin
          mul_len = SIZE_BITS'({1'b0, mid} - {1'b0, tlo} + 1'b1);
          mul_val = nd.pval;
        end
      end
      W_PUSH_A: begin
        mul_len = SIZE_BITS'({1'b0, thi} - {1'b0, mid});
        mul_val = pval_r;
      end
      default: ;
    endcase
  end

  // walk ends: clear pass over, or the root frame returns
  always_comb begin
    done_nxt = 1'b0;
    case (state_r)
      W_CLEAR: done_nxt = clr_cmd_r && (clr_addr_r == NODE_BITS'(NODE_COUNT - 1));
      W_EVAL:  done_nxt = (outside || (covers && !req.assign_op)) && (sp_r == '0);
      W_FULL:  done_nxt = (sp_r == '0);
      W_RET:   done_nxt = tph && (sp_r == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= SUM_BITS'(mul_len) * SUM_BITS'(mul_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= W_CLEAR;
      clr_addr_r <= '0;
      clr_cmd_r  <= 1'b0;
      done_r     <= 1'b0;
      sp_r       <= '0;
    end else begin
      done_r <= done_nxt;
      unique case (state_r)
        W_CLEAR: begin
          clr_addr_r <= NODE_BITS'(clr_addr_r + 1'b1);
          if (clr_addr_r == NODE_BITS'(NODE_COUNT - 1)) begin
            state_r <= W_IDLE;
          end
        end
        W_IDLE: begin
          if (req.start) begin
            if (req.clear) begin
              clr_addr_r <= '0;
              clr_cmd_r  <= 1'b1;
              state_r    <= W_CLEAR;
            end else begin
              sp_r    <= '0;
              fk[0]   <= NODE_BITS'(1);
              flo[0]  <= '0;
              fhi[0]  <= req.hi;
              state_r <= W_READ;
            end
          end
        end
        W_READ: state_r <= W_EVAL;
        W_EVAL: begin
          if (outside || (covers && !req.assign_op)) begin
            ret_r <= (outside && !req.assign_op) ? '0 : nd.sum;
            if (sp_r == '0) begin
              state_r <= W_IDLE;
            end else begin
              sp_r    <= SP_BITS'(sp_r - 1'b1);
              state_r <= W_RET;
            end
          end else if (covers) begin
            state_r <= W_FULL;
          end else if (nd.pflag) begin
            pval_r  <= nd.pval;
            nsum_r  <= nd.sum;
            state_r <= W_PUSH_A;
          end else begin
            fph[sp_r]  <= 1'b0;
            fk[sp_up]  <= kl;
            flo[sp_up] <= tlo;
            fhi[sp_up] <= mid;
            sp_r       <= sp_up;
            state_r    <= W_READ;
          end
        end
        W_FULL: begin
          ret_r <= prod_r;
          if (sp_r == '0) begin
            state_r <= W_IDLE;
          end else begin
            sp_r    <= SP_BITS'(sp_r - 1'b1);
            state_r <= W_RET;
          end
        end
        W_PUSH_A: state_r <= W_PUSH_B;
        W_PUSH_B: state_r <= W_PUSH_K;
        W_PUSH_K: begin
          fph[sp_r]  <= 1'b0;
          fk[sp_up]  <= kl;
          flo[sp_up] <= tlo;
          fhi[sp_up] <= mid;
          sp_r       <= sp_up;
          state_r    <= W_READ;
        end
        W_RET: begin
          if (!tph) begin
            // left child returned: hold its sum, descend right
            facc[sp_r] <= ret_r;
            fph[sp_r]  <= 1'b1;
            fk[sp_up]  <= kr;
            flo[sp_up] <= IDX_BITS'(mid + 1'b1);
            fhi[sp_up] <= thi;
            sp_r       <= sp_up;
            state_r    <= W_READ;
          end else begin
            ret_r <= tacc + ret_r;
            if (sp_r == '0) begin
              state_r <= W_IDLE;
            end else begin
              sp_r <= SP_BITS'(sp_r - 1'b1);
            end
          end
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != W_IDLE);
  assign rsp.done = done_r;
  assign rsp.sum  = ret_r;

endmodule

// ----- src/rara_frac.sv -----
module rara_frac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rara_pkg::SUM_BITS-1:0]  sum,
  input  logic [rara_pkg::SIZE_BITS-1:0] len,
  input  logic                           ack,
  output logic                           res_valid,
  output logic [rara_pkg::SUM_BITS-1:0]  num,
  output logic [rara_pkg::SIZE_BITS-1:0] den
);
  import rara_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_TWO, F_AODD, F_LOOP, F_DIV, F_DONE} frac_state_t;

  frac_state_t           state_r;
  logic [SUM_BITS-1:0]   a_r, b_r, sum_r, dq_r, num_r;
  logic [SIZE_BITS-1:0]  len_r, g_r, rem_r, den_r;
  logic [SH_BITS-1:0]    sh_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  den_phase_r;

  logic [SUM_BITS-1:0]   sub_a, sub_b;
  logic [SUM_BITS:0]     sub_res;
  logic                  borrow;
  logic [SIZE_BITS:0]    rem_sh;
  logic [SUM_BITS-1:0]   q_next;

  // one subtractor serves both the gcd loop and the divider
  always_comb begin
    rem_sh = {rem_r, dq_r[SUM_BITS-1]};
    if (state_r == F_DIV) begin
      sub_a = SUM_BITS'(rem_sh);
      sub_b = SUM_BITS'(g_r);
    end else begin
      sub_a = b_r;
      sub_b = a_r;
    end
    sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    borrow  = sub_res[SUM_BITS];
    q_next  = {dq_r[SUM_BITS-2:0], !borrow};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            sum_r <= sum;
            len_r <= len;
            a_r   <= sum;
            b_r   <= SUM_BITS'(len);
            sh_r  <= '0;
            if (sum == '0) begin
              num_r   <= '0;
              den_r   <= SIZE_BITS'(1);
              state_r <= F_DONE;
            end else begin
              state_r <= F_TWO;
            end
          end
        end
        F_TWO: begin
          if (!a_r[0] && !b_r[0]) begin
            a_r  <= a_r >> 1;
            b_r  <= b_r >> 1;
            sh_r <= SH_BITS'(sh_r + 1'b1);
          end else begin
            state_r <= F_AODD;
          end
        end
        F_AODD: begin
          if (!a_r[0]) begin
            a_r <= a_r >> 1;
          end else begin
            state_r <= F_LOOP;
          end
        end
        F_LOOP: begin
          if (b_r == '0) begin
            g_r         <= SIZE_BITS'(a_r << sh_r);
            dq_r        <= sum_r;
            rem_r       <= '0;
            cnt_r       <= '0;
            den_phase_r <= 1'b0;
            state_r     <= F_DIV;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else if (borrow) begin
            a_r <= b_r;
            b_r <= a_r;
          end else begin
            b_r <= sub_res[SUM_BITS-1:0];
          end
        end
        F_DIV: begin
          if (cnt_r == CNT_BITS'(SUM_BITS - 1)) begin
            if (!den_phase_r) begin
              num_r       <= q_next;
              dq_r        <= SUM_BITS'(len_r);
              rem_r       <= '0;
              cnt_r       <= '0;
              den_phase_r <= 1'b1;
            end else begin
              den_r   <= SIZE_BITS'(q_next);
              state_r <= F_DONE;
            end
          end else begin
            rem_r <= borrow ? rem_sh[SIZE_BITS-1:0] : sub_res[SIZE_BITS-1:0];
            dq_r  <= q_next;
            cnt_r <= CNT_BITS'(cnt_r + 1'b1);
          end
        end
        F_DONE: begin
          if (ack) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign res_valid = (state_r == F_DONE);
  assign num       = num_r;
  assign den       = den_r;

endmodule

// ----- src/rara_chk.sv -----
`include "assert_macros.svh"

module rara_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rara_pkg::SUM_BITS-1:0]  out_numerator,
  input logic [rara_pkg::SIZE_BITS-1:0] out_denominator
);
  import rara_pkg::*;

  // a waiting result beat holds until taken
  `RARA_ASSERT(a_out_hold, out_valid && out_stall |=>
               out_valid && $stable(out_numerator) && $stable(out_denominator))
  // reset drops the result and starts the clearing pass
  `RARA_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid)
  `RARA_ASSERT_ALWAYS(a_rst_busy, !rst_n |=> in_stall)
  // reduced length stays within the element range
  `RARA_ASSERT(a_den_range, out_valid |-> out_denominator != '0 && out_denominator <= MAX_N)
  // zero sum reduces to 0/1
  `RARA_ASSERT(a_zero_sum, out_valid && out_numerator == '0 |-> out_denominator == SIZE_BITS'(1))

endmodule

bind range_assign_range_average rara_chk u_chk (.*);
